@@ design/chtob_pkg.sv @@
`timescale 1ns / 1ps

package chtob_pkg;

	// Operation codes carried by func.
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_UPDATED   = 3'd0;
	localparam logic [2:0] ST_APPENDED  = 3'd1;
	localparam logic [2:0] ST_REMOVED   = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	// Newline bytes are skipped by the hash.
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

	// Request from the sequencer to the hash unit.
	typedef struct packed {
		logic       start;
		logic [3:0] length;
	} hash_ctl_t;

endpackage

@@ design/chtob_hash.sv @@
`timescale 1ns / 1ps

module chtob_hash #(
	parameter int LABEL_BYTES = 8,
	parameter int BUCKETS     = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  chtob_pkg::hash_ctl_t       ctl,
	input  logic [8*LABEL_BYTES-1:0]   label,
	output logic                       done,
	output logic [$clog2(BUCKETS)-1:0] bucket
);

	localparam int LW = 8 * LABEL_BYTES;
	localparam int BW = $clog2(BUCKETS);
	localparam logic [15:0] BK = 16'(BUCKETS);

	logic          run_q;
	logic          done_q;
	logic [3:0]    cnt_q;
	logic [7:0]    h_q;
	logic [LW-1:0] bytes_q;
	logic [BW-1:0] bucket_q;

	logic [7:0]  sum;
	logic [7:0]  h_next;
	logic [15:0] rem;

	assign sum = h_q + bytes_q[7:0];
	// Multiplying by 17 is the sum plus the sum shifted up four places.
	assign h_next = sum + {sum[3:0], 4'b0000};

	// Restoring reduction of the 8-bit hash by the bucket count.
	always_comb begin
		rem = {8'b0, h_q};
		for (int k = 7; k >= 0; k--) begin
			if (rem >= (BK << k)) begin
				rem = rem - (BK << k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (ctl.start) begin
				done_q  <= 1'b0;
				run_q   <= 1'b1;
				cnt_q   <= ctl.length;
				h_q     <= '0;
				bytes_q <= label;
			end else if (run_q) begin
				if (cnt_q == 4'd0) begin
					run_q    <= 1'b0;
					done_q   <= 1'b1;
					bucket_q <= rem[BW-1:0];
				end else begin
					done_q <= 1'b0;
					if (bytes_q[7:0] != chtob_pkg::NEWLINE_BYTE) begin
						h_q <= h_next;
					end
					bytes_q <= bytes_q >> 8;
					cnt_q   <= cnt_q - 4'd1;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	assign done   = done_q;
	assign bucket = bucket_q;

endmodule

@@ design/chtob_store.sv @@
`timescale 1ns / 1ps

module chtob_store #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 76
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/chained_hash_table_ordered_buckets.sv @@
`timescale 1ns / 1ps

// Keyed table of BUCKETS buckets, each an ordered list of up to SLOTS entries
// (label of up to LABEL_BYTES bytes, 8-bit value), one insert or remove per
// input beat and one result beat for each. The block works on one item at a
// time and takes no new input beat until the last result has moved to the
// output register: the hash unit takes the label one byte per cycle up to its
// saturated length, each entry compared takes a read and a compare on the
// single entry memory port, and each entry moved up on a remove takes a read
// and a write. A finished result waits in an output register while the next
// input beat is accepted. Bucket counts sit in a small memory with one valid
// flop per bucket, so no clearing pass follows reset.
module chained_hash_table_ordered_buckets #(
	parameter int BUCKETS     = 256,
	parameter int SLOTS       = 8,
	parameter int LABEL_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [63:0] label_bytes,
	input  logic [3:0]  label_length,
	input  logic [7:0]  new_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  bucket,
	output logic [2:0]  slot,
	output logic [2:0]  status
);

	localparam int LW      = 8 * LABEL_BYTES;
	localparam int EW      = LW + 12;
	localparam int BW      = $clog2(BUCKETS);
	localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FW      = $clog2(SLOTS + 1);
	localparam int FW1     = FW + 1;
	localparam int ENTRIES = BUCKETS * SLOTS;
	localparam int AW      = $clog2(ENTRIES);
	localparam int AW1     = AW + 1;
	localparam logic [FW-1:0] SLOTS_F = FW'(SLOTS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_HASH,
		S_FILL_RD,
		S_FILL_TAKE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_RESOLVE,
		S_SH_RD,
		S_SH_WR,
		S_DONE
	} state_t;

	state_t state_q;

	logic          func_q;
	logic [LW-1:0] label_q;
	logic [3:0]    len_q;
	logic [7:0]    value_q;
	logic [BW-1:0] bucket_q;
	logic [AW-1:0] base_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] idx_q;
	logic          found_q;
	logic [SW-1:0] slot_q;
	logic [2:0]    status_q;

	logic          out_valid_q;
	logic [BW-1:0] out_bucket_q;
	logic [SW-1:0] out_slot_q;
	logic [2:0]    out_status_q;

	logic [FW-1:0] fill_mem [BUCKETS];
	logic [BUCKETS-1:0] fill_vld_q;
	logic [FW-1:0] fill_rd_q;
	logic          fill_rd_vld_q;
	logic          fill_we;
	logic [FW-1:0] fill_wdata;
	logic [FW-1:0] fill_now;

	logic [3:0]    len_sat;
	logic [LW-1:0] label_in;
	logic          accept;

	chtob_pkg::hash_ctl_t hash_ctl;
	logic          hash_done;
	logic [BW-1:0] hash_bucket;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	logic          match;

	logic [SW+2:0] slot_pad;

	assign accept  = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	assign len_sat = (label_length > 4'(LABEL_BYTES)) ? 4'(LABEL_BYTES) : label_length;

	// Bytes at and past the length are cleared so stored labels compare whole.
	always_comb begin
		label_in = label_bytes[LW-1:0];
		for (int j = 0; j < LABEL_BYTES; j++) begin
			if (4'(j) >= len_sat) begin
				label_in[8*j +: 8] = 8'h00;
			end
		end
	end

	assign hash_ctl.start  = accept;
	assign hash_ctl.length = len_sat;

	chtob_hash #(
		.LABEL_BYTES(LABEL_BYTES),
		.BUCKETS    (BUCKETS)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (hash_ctl),
		.label (label_in),
		.done  (hash_done),
		.bucket(hash_bucket)
	);

	chtob_store #(
		.DEPTH(ENTRIES),
		.WIDTH(EW)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign match = (ram_rdata[11:8] == len_q) && (ram_rdata[EW-1 -: LW] == label_q);
	assign fill_now = fill_rd_vld_q ? fill_rd_q : '0;

	assign ram_raddr = (state_q == S_SH_RD) ? base_q + AW'(idx_q) + AW'(1)
	                                        : base_q + AW'(idx_q);

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = base_q + AW'(idx_q);
		ram_wdata  = ram_rdata;
		fill_we    = 1'b0;
		fill_wdata = fill_q;
		if (state_q == S_RESOLVE) begin
			if (func_q == chtob_pkg::FUNC_INSERT) begin
				ram_wdata = {label_q, len_q, value_q};
				if (found_q) begin
					ram_we = 1'b1;
				end else if (fill_q < SLOTS_F) begin
					ram_we     = 1'b1;
					ram_waddr  = base_q + AW'(fill_q);
					fill_we    = 1'b1;
					fill_wdata = fill_q + FW'(1);
				end
			end else if (found_q) begin
				fill_we    = 1'b1;
				fill_wdata = fill_q - FW'(1);
			end
		end else if (state_q == S_SH_WR) begin
			ram_we = 1'b1;
		end
	end

	// Bucket count memory with registered read.
	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[bucket_q] <= fill_wdata;
		end
		fill_rd_q <= fill_mem[bucket_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q    <= '0;
			fill_rd_vld_q <= 1'b0;
		end else begin
			if (fill_we) begin
				fill_vld_q[bucket_q] <= 1'b1;
			end
			fill_rd_vld_q <= fill_vld_q[bucket_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q  <= func;
						label_q <= label_in;
						len_q   <= len_sat;
						value_q <= new_value;
						found_q <= 1'b0;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						bucket_q <= hash_bucket;
						state_q  <= S_FILL_RD;
					end
				end
				S_FILL_RD: begin
					base_q  <= AW'(32'(bucket_q) * SLOTS);
					state_q <= S_FILL_TAKE;
				end
				S_FILL_TAKE: begin
					fill_q <= fill_now;
					idx_q  <= '0;
					if (fill_now == '0) begin
						state_q <= S_RESOLVE;
					end else begin
						state_q <= S_SRCH_RD;
					end
				end
				S_SRCH_RD: begin
					state_q <= S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					if (match) begin
						found_q <= 1'b1;
						state_q <= S_RESOLVE;
					end else if (idx_q + FW'(1) == fill_q) begin
						state_q <= S_RESOLVE;
					end else begin
						idx_q   <= idx_q + FW'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_RESOLVE: begin
					if (func_q == chtob_pkg::FUNC_INSERT) begin
						state_q <= S_DONE;
						if (found_q) begin
							slot_q   <= SW'(idx_q);
							status_q <= chtob_pkg::ST_UPDATED;
						end else if (fill_q < SLOTS_F) begin
							slot_q   <= SW'(fill_q);
							status_q <= chtob_pkg::ST_APPENDED;
						end else begin
							slot_q   <= '0;
							status_q <= chtob_pkg::ST_FULL;
						end
					end else if (found_q) begin
						slot_q   <= SW'(idx_q);
						status_q <= chtob_pkg::ST_REMOVED;
						if (FW1'(idx_q) + FW1'(1) < FW1'(fill_q)) begin
							state_q <= S_SH_RD;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q  <= S_DONE;
						slot_q   <= '0;
						status_q <= chtob_pkg::ST_NOT_FOUND;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					idx_q <= idx_q + FW'(1);
					if (FW1'(idx_q) + FW1'(2) < FW1'(fill_q)) begin
						state_q <= S_SH_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_bucket_q <= bucket_q;
						out_slot_q   <= slot_q;
						out_status_q <= status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign slot_pad  = {3'b000, out_slot_q};
	assign out_valid = out_valid_q;
	assign bucket    = 8'(out_bucket_q);
	assign slot      = slot_pad[2:0];
	assign status    = out_status_q;

	// A bucket count never grows past the bucket size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> fill_wdata <= SLOTS_F)
		else $error("bucket count written above bucket size");

	// Entry writes stay inside the current bucket.
	a_write_in_bucket: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_waddr >= base_q) && (AW1'(ram_waddr) < AW1'(base_q) + AW1'(SLOTS)))
		else $error("entry write outside the current bucket");

	// The hash unit only finishes while the sequencer waits for it.
	a_hash_done: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> state_q == S_HASH)
		else $error("hash result arrived outside the hash wait");

	// Results with nothing touched report position zero.
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == chtob_pkg::ST_FULL || status == chtob_pkg::ST_NOT_FOUND)
		|-> slot == 3'd0)
		else $error("nonzero slot on a result that changed nothing");

endmodule
